### rtl/core/rqhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqhs_pkg
// Shared constants, codes and types of the run queue with hand-off and steal.
// ----------------------------------------------------------------------------
package rqhs_pkg;

  // default sizing
  localparam int NumWorkersDef = 8;
  localparam int FifoDepthDef  = 64;
  localparam int TaskBitsDef   = 10;

  // fixed field widths
  localparam int OpW       = 2;
  localparam int WorkerW   = 3;
  localparam int TimeW     = 32;
  localparam int StatusW   = 2;
  localparam int SourceW   = 2;
  localparam int VictimW   = 3;
  localparam int ActW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 32;
  localparam int ScanW     = 7;  // holds 0..127

  // register reset values
  localparam logic [TimeW-1:0] StealAgeRst      = 32'd5000;
  localparam logic [ActW-1:0]  ActiveWorkersRst = 4'd8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_STEAL_AGE      = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_WORKERS = 1'd1;

  // opcodes
  localparam logic [OpW-1:0] OP_ENQ   = 2'd0;
  localparam logic [OpW-1:0] OP_WTAKE = 2'd1;
  localparam logic [OpW-1:0] OP_MTAKE = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd1;
  localparam logic [StatusW-1:0] ST_NOWORK = 2'd2;

  // source codes
  localparam logic [SourceW-1:0] SRC_OWN    = 2'd0;
  localparam logic [SourceW-1:0] SRC_SHARED = 2'd1;
  localparam logic [SourceW-1:0] SRC_STOLEN = 2'd2;
  localparam logic [SourceW-1:0] SRC_MAIN   = 2'd3;

  // FIFO control and status
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### rtl/core/rqhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqhs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqhs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rqhs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqhs_fifo
// Task FIFO: head pointer and fill count over a RAM; registered pop data.
// ----------------------------------------------------------------------------
module rqhs_fifo import rqhs_pkg::*; #(
  parameter int WIDTH = TaskBitsDef,
  parameter int DEPTH = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fifo_req_t        req_i,
  input  logic [WIDTH-1:0] wdata_i,
  output fifo_stat_t       stat_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DepthS = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullC  = CW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] waddr;

  // tail = (head + count) mod DEPTH, sum stays below twice the depth
  assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign waddr    = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.pop) begin
      head_d = (head_q == LastA) ? '0 : head_q + 1'b1;
    end
    if (req_i.push && !req_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (req_i.pop && !req_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full  = (count_q == FullC);
  assign stat_o.empty = (count_q == '0);

  rqhs_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (waddr),
    .wdata_i (wdata_i),
    .re_i    (req_i.pop),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule

### rtl/core/rqhs_age_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqhs_age_unit
// Slot age check: (now - stamp) mod 2^32 strictly above the steal age.
// ----------------------------------------------------------------------------
module rqhs_age_unit import rqhs_pkg::*; (
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeW-1:0] stamp_i,
  input  logic [TimeW-1:0] steal_age_i,
  output logic             old_o
);

  logic [TimeW-1:0] age;

  assign age   = now_i - stamp_i;
  assign old_o = (age > steal_age_i);

endmodule

### rtl/core/run_queue_with_handoff_and_steal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_queue_with_handoff_and_steal
// Task dispatcher: per-worker hand-off slots, shared FIFO, main FIFO, stealing.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start_i high and busy_o low; its one
// result appears for exactly one cycle with done_o high and must be captured
// then, as there is no way to hold it off. A new item may be started in the
// cycle that shows done_o. An enqueue, a take from the own slot, an empty
// main take or an unused opcode finishes in the execute state; a take that
// pops either FIFO then passes through the pop-wait state for the registered
// RAM read; a worker take that falls through to stealing scans from slot 0
// upward until a slot is stolen or n slots are checked, n being
// min(active_workers, NUM_WORKERS), making one age compare per slot per cycle
// through the shared age unit. No clearing pass after reset; FIFO RAMs are tracked by fill count.
// ----------------------------------------------------------------------------
module run_queue_with_handoff_and_steal import rqhs_pkg::*; #(
  parameter int NUM_WORKERS = NumWorkersDef,
  parameter int FIFO_DEPTH  = FifoDepthDef,
  parameter int TASK_BITS   = TaskBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [TASK_BITS-1:0] task_id_i,
  input  logic                 to_main_i,
  input  logic                 from_worker_i,
  input  logic [WorkerW-1:0]   worker_i,
  input  logic [TimeW-1:0]     now_time_i,
  // result channel
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [TASK_BITS-1:0] out_task_o,
  output logic [SourceW-1:0]   source_o,
  output logic [VictimW-1:0]   victim_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  localparam int SW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam logic [ScanW-1:0] NwV = ScanW'(NUM_WORKERS);

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_SCAN    = 2'd2;
  localparam logic [1:0] S_POPWAIT = 2'd3;

  logic [1:0] state_q, state_d;

  // latched item
  logic [OpW-1:0]       op_q;
  logic [TASK_BITS-1:0] task_q;
  logic                 to_main_q;
  logic                 from_worker_q;
  logic [WorkerW-1:0]   worker_q;
  logic [TimeW-1:0]     now_q;

  // config
  logic [TimeW-1:0] steal_age_q;
  logic [ActW-1:0]  active_q;

  // hand-off slots
  logic [NUM_WORKERS-1:0] slot_valid_q;
  logic [TASK_BITS-1:0]   slot_task_q  [NUM_WORKERS];
  logic [TimeW-1:0]       slot_stamp_q [NUM_WORKERS];

  // scan and pending pop source
  logic [ScanW-1:0]   scan_q, scan_d;
  logic [SourceW-1:0] pend_q, pend_d;

  // result registers
  logic                 done_q;
  logic [StatusW-1:0]   status_q;
  logic [TASK_BITS-1:0] out_task_q;
  logic [SourceW-1:0]   source_q;
  logic [VictimW-1:0]   victim_q;

  // finishing values
  logic                 fin;
  logic [StatusW-1:0]   fin_status;
  logic [TASK_BITS-1:0] fin_task;
  logic [SourceW-1:0]   fin_source;
  logic [VictimW-1:0]   fin_victim;

  // slot control
  logic          slot_wr;
  logic          slot_clr;
  logic [SW-1:0] w_idx;
  logic [SW-1:0] rd_idx;
  logic          has_slot;
  logic [ScanW-1:0] wk_ext;
  logic [ScanW-1:0] scan_lim;
  logic [TASK_BITS-1:0] rd_task;
  logic [TimeW-1:0]     rd_stamp;
  logic                 rd_valid;
  logic                 rd_old;

  // FIFOs
  fifo_req_t            sh_req, mn_req;
  fifo_stat_t           sh_stat, mn_stat;
  logic [TASK_BITS-1:0] sh_wdata;
  logic [TASK_BITS-1:0] sh_rdata, mn_rdata;

  assign wk_ext   = ScanW'(worker_q);
  assign has_slot = (wk_ext < NwV);
  assign w_idx    = wk_ext[SW-1:0];
  assign scan_lim = (ScanW'(active_q) > NwV) ? NwV : ScanW'(active_q);

  // single slot read port: own slot while executing, scan pointer otherwise
  assign rd_idx   = (state_q == S_EXEC) ? w_idx : scan_q[SW-1:0];
  assign rd_task  = slot_task_q[rd_idx];
  assign rd_stamp = slot_stamp_q[rd_idx];
  assign rd_valid = slot_valid_q[rd_idx];

  rqhs_age_unit u_age (
    .now_i       (now_q),
    .stamp_i     (rd_stamp),
    .steal_age_i (steal_age_q),
    .old_o       (rd_old)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_task   = '0;
    fin_source = SRC_OWN;
    fin_victim = '0;
    sh_req     = '0;
    mn_req     = '0;
    sh_wdata   = task_q;
    slot_wr    = 1'b0;
    slot_clr   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (op_q)
          OP_ENQ: begin
            fin = 1'b1;
            if (to_main_q) begin
              if (mn_stat.full) begin
                fin_status = ST_FULL;
              end else begin
                mn_req.push = 1'b1;
              end
            end else if (from_worker_q && has_slot) begin
              // new task takes the slot; any occupant goes to the shared FIFO, or is lost if it is full
              slot_wr = 1'b1;
              if (rd_valid) begin
                sh_wdata = rd_task;
                if (sh_stat.full) begin
                  fin_status = ST_FULL;
                end else begin
                  sh_req.push = 1'b1;
                end
              end
            end else begin
              if (sh_stat.full) begin
                fin_status = ST_FULL;
              end else begin
                sh_req.push = 1'b1;
              end
            end
          end

          OP_WTAKE: begin
            if (has_slot && rd_valid) begin
              fin      = 1'b1;
              fin_task = rd_task;
              slot_clr = 1'b1;
            end else if (!sh_stat.empty) begin
              sh_req.pop = 1'b1;
              pend_d     = SRC_SHARED;
              state_d    = S_POPWAIT;
            end else begin
              scan_d  = '0;
              state_d = S_SCAN;
            end
          end

          OP_MTAKE: begin
            if (!mn_stat.empty) begin
              mn_req.pop = 1'b1;
              pend_d     = SRC_MAIN;
              state_d    = S_POPWAIT;
            end else begin
              fin        = 1'b1;
              fin_status = ST_NOWORK;
            end
          end

          default: begin
            fin        = 1'b1;
            fin_status = ST_NOWORK;
          end
        endcase
      end

      S_SCAN: begin
        // lowest-indexed slot old enough wins
        priority if (scan_q >= scan_lim) begin
          fin        = 1'b1;
          fin_status = ST_NOWORK;
        end else if (rd_valid && rd_old) begin
          fin        = 1'b1;
          fin_task   = rd_task;
          fin_source = SRC_STOLEN;
          fin_victim = scan_q[VictimW-1:0];
          slot_clr   = 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_POPWAIT: begin
        fin        = 1'b1;
        fin_task   = (pend_q == SRC_MAIN) ? mn_rdata : sh_rdata;
        fin_source = pend_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= '0;
      pend_q       <= SRC_OWN;
      done_q       <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      done_q  <= fin;
      if (slot_wr) begin
        slot_valid_q[rd_idx] <= 1'b1;
      end else if (slot_clr) begin
        slot_valid_q[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steal_age_q <= StealAgeRst;
      active_q    <= ActiveWorkersRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STEAL_AGE) begin
        steal_age_q <= cfg_wdata_i;
      end else if (cfg_idx_i == REG_ACTIVE_WORKERS) begin
        active_q <= cfg_wdata_i[ActW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q          <= opcode_i;
      task_q        <= task_id_i;
      to_main_q     <= to_main_i;
      from_worker_q <= from_worker_i;
      worker_q      <= worker_i;
      now_q         <= now_time_i;
    end
    if (slot_wr) begin
      slot_task_q[rd_idx]  <= task_q;
      slot_stamp_q[rd_idx] <= now_q;
    end
    if (fin) begin
      status_q   <= fin_status;
      out_task_q <= fin_task;
      source_q   <= fin_source;
      victim_q   <= fin_victim;
    end
  end

  // --------------------------------------------------------------------------
  // FIFOs
  // --------------------------------------------------------------------------
  rqhs_fifo #(
    .WIDTH (TASK_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_shared_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sh_req),
    .wdata_i (sh_wdata),
    .stat_o  (sh_stat),
    .rdata_o (sh_rdata)
  );

  rqhs_fifo #(
    .WIDTH (TASK_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_main_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mn_req),
    .wdata_i (task_q),
    .stat_o  (mn_stat),
    .rdata_o (mn_rdata)
  );

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign out_task_o = out_task_q;
  assign source_o   = source_q;
  assign victim_o   = victim_q;

endmodule

### dv/rqhs_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqhs_tb_pkg
// Item types and the dispatch scoreboard for the run queue testbench.
// ----------------------------------------------------------------------------
package rqhs_tb_pkg;
  import rqhs_pkg::*;

  // opcode 3 has no meaning in the block; it must report no work
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef logic [TaskBitsDef-1:0] task_t;
  typedef logic [TimeW-1:0]       stamp_t;

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    task_t              task_id;
    logic               to_main;
    logic               from_worker;
    logic [WorkerW-1:0] worker;
    stamp_t             now_time;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    task_t              out_task;
    logic [SourceW-1:0] source;
    logic [VictimW-1:0] victim;
  } outcome_t;

  class rq_scoreboard;
    task_t          shared_q[$];
    task_t          main_q[$];
    bit             slot_valid[NumWorkersDef];
    task_t          slot_task[NumWorkersDef];
    stamp_t         slot_stamp[NumWorkersDef];
    stamp_t         steal_age;
    logic [ActW-1:0] active_workers;
    outcome_t       due_results[$];
    int unsigned    mismatches;

    function new();
      steal_age      = StealAgeRst;
      active_workers = ActiveWorkersRst;
      mismatches     = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_STEAL_AGE:      steal_age      = data;
        REG_ACTIVE_WORKERS: active_workers = data[ActW-1:0];
        default: ;
      endcase
    endfunction

    // one command against the queue state; returns its single outcome
    function outcome_t dispatch(cmd_t c);
      outcome_t r;
      int       scan;
      bit       has_slot;
      stamp_t   age;
      r        = '0;
      r.status = ST_OK;
      has_slot = int'(c.worker) < NumWorkersDef;
      case (c.opcode)
        OP_ENQ: begin
          if (c.to_main) begin
            if (main_q.size() >= FifoDepthDef) r.status = ST_FULL;
            else main_q.push_back(c.task_id);
          end else if (c.from_worker && has_slot) begin
            // occupant is displaced into the shared queue, or lost if full
            if (slot_valid[c.worker]) begin
              if (shared_q.size() >= FifoDepthDef) r.status = ST_FULL;
              else shared_q.push_back(slot_task[c.worker]);
            end
            slot_valid[c.worker] = 1'b1;
            slot_task[c.worker]  = c.task_id;
            slot_stamp[c.worker] = c.now_time;
          end else begin
            if (shared_q.size() >= FifoDepthDef) r.status = ST_FULL;
            else shared_q.push_back(c.task_id);
          end
        end
        OP_WTAKE: begin
          if (has_slot && slot_valid[c.worker]) begin
            slot_valid[c.worker] = 1'b0;
            r.out_task = slot_task[c.worker];
            r.source   = SRC_OWN;
          end else if (shared_q.size() != 0) begin
            r.out_task = shared_q.pop_front();
            r.source   = SRC_SHARED;
          end else begin
            scan     = (active_workers > NumWorkersDef) ? NumWorkersDef : int'(active_workers);
            r.status = ST_NOWORK;
            for (int i = 0; i < scan; i++) begin
              age = c.now_time - slot_stamp[i];
              if (slot_valid[i] && age > steal_age) begin
                slot_valid[i] = 1'b0;
                r.status   = ST_OK;
                r.out_task = slot_task[i];
                r.source   = SRC_STOLEN;
                r.victim   = VictimW'(i);
                break;
              end
            end
          end
        end
        OP_MTAKE: begin
          if (main_q.size() != 0) begin
            r.out_task = main_q.pop_front();
            r.source   = SRC_MAIN;
          end else begin
            r.status = ST_NOWORK;
          end
        end
        default: r.status = ST_NOWORK;
      endcase
      return r;
    endfunction

    function void note_command(cmd_t c);
      due_results.push_back(dispatch(c));
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      bit       bad;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing outstanding: st=%0d task=%0d src=%0d vic=%0d",
                   $realtime, got.status, got.out_task, got.source, got.victim);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      bad  = (got.status !== want.status) || (got.out_task !== want.out_task) ||
             (got.source !== want.source) || (got.victim !== want.victim);
      if (bad) begin
        if (mismatches < 10)
          $display({"%0t: mismatch: exp st=%0d task=%0d src=%0d vic=%0d,",
                    " got st=%0d task=%0d src=%0d vic=%0d"},
                   $realtime, want.status, want.out_task, want.source, want.victim,
                   got.status, got.out_task, got.source, got.victim);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### dv/run_queue_with_handoff_and_steal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_queue_with_handoff_and_steal_tb
// Self-checking bench for the task dispatcher: a short directed run through
// hand-off, displacement, the shared and main queues and slot stealing, then
// random phases that fill and drain both queues under varied steal settings.
// Every result is compared with a predictor kept in the scoreboard.
// ----------------------------------------------------------------------------
module run_queue_with_handoff_and_steal_tb;
  import rqhs_pkg::*;
  import rqhs_tb_pkg::*;

  // load profiles for the random phases
  typedef enum int {LOAD_FILL, LOAD_DRAIN, LOAD_MIX} load_e;

  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 95;
  localparam int SettleCycles  = 16;  // long enough for the slowest item, a steal scan over every slot

  logic                   clk = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [OpW-1:0]         opcode_i;
  logic [TaskBitsDef-1:0] task_id_i;
  logic                   to_main_i;
  logic                   from_worker_i;
  logic [WorkerW-1:0]     worker_i;
  logic [TimeW-1:0]       now_time_i;
  logic                   done_o;
  logic [StatusW-1:0]     status_o;
  logic [TaskBitsDef-1:0] out_task_o;
  logic [SourceW-1:0]     source_o;
  logic [VictimW-1:0]     victim_o;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgDataW-1:0]    cfg_wdata_i;

  rq_scoreboard sb;

  stamp_t      now_stamp;   // running time base for random items
  int unsigned burst_left;  // items still to go with no idling

  run_queue_with_handoff_and_steal dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .task_id_i     (task_id_i),
    .to_main_i     (to_main_i),
    .from_worker_i (from_worker_i),
    .worker_i      (worker_i),
    .now_time_i    (now_time_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_task_o    (out_task_o),
    .source_o      (source_o),
    .victim_o      (victim_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk = ~clk;

  // watchdog: far beyond the slowest legal run of about 1k items
  initial begin
    #5ms;
    $display("FAIL run_queue_with_handoff_and_steal");
    $finish;
  end

  // result capture: done_o is a one-cycle strobe, sampled at the edge closing it
  always @(posedge clk) begin
    if (rst_ni && done_o) begin
      sb.check_result('{status: status_o, out_task: out_task_o,
                        source: source_o, victim: victim_o});
    end
  end

  function automatic cmd_t mk(logic [OpW-1:0] op, task_t tid, logic tm, logic fw,
                              logic [WorkerW-1:0] w, stamp_t now);
    cmd_t c;
    c.opcode      = op;
    c.task_id     = tid;
    c.to_main     = tm;
    c.from_worker = fw;
    c.worker      = w;
    c.now_time    = now;
    return c;
  endfunction

  // random item; time creeps forward, with the odd jump to exercise wrap-round
  function automatic cmd_t draw_command(load_e load);
    cmd_t        c;
    int unsigned pick;
    int unsigned enq_cut;
    int unsigned wtake_cut;
    int unsigned mtake_cut;
    case (load)
      LOAD_FILL:  begin enq_cut = 85; wtake_cut = 93; mtake_cut = 98; end
      LOAD_DRAIN: begin enq_cut = 25; wtake_cut = 80; mtake_cut = 96; end
      default:    begin enq_cut = 50; wtake_cut = 82; mtake_cut = 97; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < enq_cut)        c.opcode = OP_ENQ;
    else if (pick < wtake_cut) c.opcode = OP_WTAKE;
    else if (pick < mtake_cut) c.opcode = OP_MTAKE;
    else                       c.opcode = OP_UNUSED;
    c.task_id = task_t'($urandom);
    c.worker  = WorkerW'($urandom_range(0, 7));
    // while draining, enqueues mostly land in slots so the shared queue
    // stays empty and the steal scan gets exercised
    if (load == LOAD_DRAIN) begin
      c.to_main     = ($urandom_range(0, 4) == 0);
      c.from_worker = ($urandom_range(0, 4) != 0);
    end else begin
      c.to_main     = ($urandom_range(0, 2) == 0);
      c.from_worker = ($urandom_range(0, 1) != 0);
    end
    if ($urandom_range(0, 39) == 0) now_stamp = $urandom;
    else now_stamp = now_stamp + $urandom_range(0, 40);
    c.now_time = now_stamp;
    return c;
  endfunction

  // sender gap before the next item; bursts give stretches with no idling
  task automatic idle_gap();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(8, 24);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // present one item and hold it until taken; start stays high on return
  task automatic send_command(input cmd_t c);
    start_i       <= 1'b1;
    opcode_i      <= c.opcode;
    task_id_i     <= c.task_id;
    to_main_i     <= c.to_main;
    from_worker_i <= c.from_worker;
    worker_i      <= c.worker;
    now_time_i    <= c.now_time;
    do @(posedge clk); while (busy_o);
    sb.note_command(c);
  endtask

  // drop start, let every outstanding result arrive, then settle
  task automatic wait_drain();
    start_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  initial begin
    cmd_t            opening[$];
    stamp_t          age_plan[NumPhases];
    logic [ActW-1:0] width_plan[NumPhases];
    load_e           load_plan[NumPhases];

    sb         = new();
    burst_left = 0;
    now_stamp  = '0;

    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    opcode_i      <= OP_ENQ;
    task_id_i     <= '0;
    to_main_i     <= 1'b0;
    from_worker_i <= 1'b0;
    worker_i      <= '0;
    now_time_i    <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_STEAL_AGE;
    cfg_wdata_i   <= '0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed opening, reset settings (steal age 5000, eight slots scanned)
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'h0000_0000)); // all empty
    opening.push_back(mk(OP_MTAKE,  10'h3FF, 1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF)); // main empty
    opening.push_back(mk(OP_UNUSED, 10'h3FF, 1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF));
    opening.push_back(mk(OP_ENQ,    10'h3FF, 1'b1, 1'b1, 3'd7, 32'h0000_0000)); // main wins
    opening.push_back(mk(OP_ENQ,    10'h000, 1'b0, 1'b0, 3'd0, 32'h0000_0000)); // to shared
    opening.push_back(mk(OP_ENQ,    10'h155, 1'b0, 1'b1, 3'd7, 32'hFFFF_FFFF)); // hand-off
    opening.push_back(mk(OP_ENQ,    10'h2AA, 1'b0, 1'b1, 3'd7, 32'h0000_0000)); // displaces
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd7, 32'h0000_0000)); // own slot
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'h0000_0000)); // shared
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'h0000_0000)); // displaced one
    opening.push_back(mk(OP_MTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'h0000_0000)); // main
    opening.push_back(mk(OP_ENQ,    10'h005, 1'b0, 1'b1, 3'd3, 32'd100));
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'd5100));      // age = limit
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd0, 32'd5101));      // just over
    opening.push_back(mk(OP_ENQ,    10'h1F0, 1'b0, 1'b1, 3'd6, 32'hFFFF_FF00));
    opening.push_back(mk(OP_ENQ,    10'h00F, 1'b0, 1'b1, 3'd2, 32'h0000_2000));
    // stamp ahead of now looks very old after wrap; lower index goes first
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd1, 32'h0000_1400));
    // slot 6 age spans the wrap of the time base
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd1, 32'h0000_1400));
    opening.push_back(mk(OP_WTAKE,  10'h000, 1'b0, 1'b0, 3'd5, 32'h0000_0000));
    foreach (opening[i]) begin
      idle_gap();
      send_command(opening[i]);
    end

    // phase plan: extremes of both registers, fills ahead of drains
    age_plan[0] = 32'd0;                 width_plan[0] = 4'd8;  load_plan[0] = LOAD_FILL;
    age_plan[1] = 32'hFFFF_FFFF;         width_plan[1] = 4'd1;  load_plan[1] = LOAD_FILL;
    age_plan[2] = 32'd20;                width_plan[2] = 4'd0;  load_plan[2] = LOAD_FILL;
    age_plan[3] = 32'd50;                width_plan[3] = 4'd15; load_plan[3] = LOAD_DRAIN;
    age_plan[4] = $urandom_range(0, 200);
    width_plan[4] = ActW'($urandom_range(1, 8));                load_plan[4] = LOAD_DRAIN;
    age_plan[5] = $urandom;
    width_plan[5] = ActW'($urandom_range(0, 15));               load_plan[5] = LOAD_MIX;
    age_plan[6] = StealAgeRst;           width_plan[6] = 4'd8;  load_plan[6] = LOAD_FILL;
    age_plan[7] = 32'd1;                 width_plan[7] = 4'd3;  load_plan[7] = LOAD_FILL;
    age_plan[8] = 32'd30;                width_plan[8] = 4'd7;  load_plan[8] = LOAD_DRAIN;
    age_plan[9] = $urandom_range(0, 100);
    width_plan[9] = ActW'($urandom_range(0, 15));               load_plan[9] = LOAD_MIX;

    now_stamp = $urandom;
    for (int p = 0; p < NumPhases; p++) begin
      // registers only change with the block idle and nothing outstanding
      wait_drain();
      write_register(REG_STEAL_AGE, age_plan[p]);
      write_register(REG_ACTIVE_WORKERS, CfgDataW'(width_plan[p]));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        idle_gap();
        send_command(draw_command(load_plan[p]));
      end
    end

    wait_drain();
    if (sb.mismatches == 0) begin
      $display("PASS run_queue_with_handoff_and_steal");
    end else begin
      $display("FAIL run_queue_with_handoff_and_steal");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rqhs_pkg.sv
rtl/core/rqhs_ram.sv
rtl/core/rqhs_fifo.sv
rtl/core/rqhs_age_unit.sv
rtl/core/run_queue_with_handoff_and_steal.sv
dv/rqhs_tb_pkg.sv
dv/run_queue_with_handoff_and_steal_tb.sv
